>>> design/rv64id_pkg.sv
package rv64id_pkg;

    localparam int XLEN    = 64;
    localparam int SHAMT_W = $clog2(XLEN);

    // Major opcodes
    localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;

    // funct3 codes
    localparam logic [2:0] F3_ADD      = 3'd0;
    localparam logic [2:0] F3_SLL      = 3'd1;
    localparam logic [2:0] F3_SLT      = 3'd2;
    localparam logic [2:0] F3_SLTU     = 3'd3;
    localparam logic [2:0] F3_XOR      = 3'd4;
    localparam logic [2:0] F3_SR       = 3'd5;
    localparam logic [2:0] F3_OR       = 3'd6;
    localparam logic [2:0] F3_AND      = 3'd7;
    localparam logic [2:0] F3_JALR     = 3'd0;
    localparam logic [2:0] F3_LD_RSVD  = 3'd7;

    // Upper bits of shift-immediate encodings
    localparam logic [5:0] TOP6_LOGIC  = 6'b000000;
    localparam logic [5:0] TOP6_ARITH  = 6'b010000;

    // Load access sizes
    localparam logic [1:0] SIZE_BYTE   = 2'd0;
    localparam logic [1:0] SIZE_HALF   = 2'd1;
    localparam logic [1:0] SIZE_WORD   = 2'd2;
    localparam logic [1:0] SIZE_DOUBLE = 2'd3;

    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_ADD,
        ALU_SLT,
        ALU_SLTU,
        ALU_XOR,
        ALU_OR,
        ALU_AND,
        ALU_SLL,
        ALU_SRL,
        ALU_SRA,
        ALU_LINK
    } alu_op_t;

    // Decoded control, all fields zero for an unmatched word
    typedef struct packed {
        logic        matched;
        logic        take_branch;
        logic        from_memory;
        logic        load_unsigned;
        logic [1:0]  access_size;
        alu_op_t     alu_op;
        logic [11:0] imm_raw;
        logic [11:0] imm_out;
        logic [4:0]  dest_index;
        logic [4:0]  source_index;
    } ctrl_t;

    // Input transfer, last field in the low bits
    typedef struct packed {
        logic [XLEN-1:0] memory_word;
        logic [XLEN-1:0] program_counter;
        logic [XLEN-1:0] source_value;
        logic [31:0]     instruction;
    } item_t;

    // Result transfer, last field in the low bits
    typedef struct packed {
        logic [XLEN-1:0] loaded_value;
        logic [1:0]      access_size;
        logic            from_memory;
        logic            write_register;
        logic            take_branch;
        logic [XLEN-1:0] alu_result;
        logic [11:0]     immediate;
        logic [4:0]      source_index;
        logic [4:0]      dest_index;
        logic            matched;
    } result_t;

    localparam int IN_TDATA_W  = (($bits(item_t) + 7) / 8) * 8;
    localparam int OUT_TDATA_W = (($bits(result_t) + 7) / 8) * 8;

endpackage

>>> design/rv64i_itype_decode_execute_unit.sv
// Channel   Dir  Width  Contents
// s_axis    in   224    instruction, source_value, program_counter, memory_word
// m_axis    out  160    decoded fields, ALU result, control flags, load value
//
// One instruction per clock while m_axis_tready stays high; each result is
// registered twice on its way out (input register, then result register).
// Decode, ALU and load extension sit between the two registers.
// rst_n clears both valid bits; payload registers are not reset.
// A stall on m_axis holds the result register; the input register keeps
// accepting until it too is full, so ready is not a state flag.
module rv64i_itype_decode_execute_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [31:0] instruction, [95:32] source_value, [159:96] program_counter,
    // [223:160] memory_word
    input  logic [rv64id_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [0] matched, [5:1] dest_index, [10:6] source_index, [22:11] immediate,
    // [86:23] alu_result, [87] take_branch, [88] write_register,
    // [89] from_memory, [91:90] access_size, [155:92] loaded_value,
    // [159:156] zero
    output logic [rv64id_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import rv64id_pkg::*;

    // input stage
    logic    s1_valid_reg;
    logic    s1_valid_next;
    item_t   s1_item_reg;
    logic    s1_ready;

    // result stage
    logic    s2_valid_reg;
    logic    s2_valid_next;
    result_t s2_result_reg;
    result_t s2_result_next;
    logic    s2_ready;

    ctrl_t           ctrl;
    logic [XLEN-1:0] alu_result;
    logic [XLEN-1:0] loaded_value;

    // Ready chain: each stage frees up when it is empty or moving on
    assign s2_ready      = !s2_valid_reg || m_axis_tready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;

    assign s1_valid_next = s1_ready ? s_axis_tvalid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg  : s2_valid_reg;

    rv64id_decode u_decode (
        .instruction (s1_item_reg.instruction),
        .ctrl        (ctrl)
    );

    rv64id_alu u_alu (
        .ctrl            (ctrl),
        .source_value    (s1_item_reg.source_value),
        .program_counter (s1_item_reg.program_counter),
        .alu_result      (alu_result)
    );

    rv64id_load_ext u_load_ext (
        .ctrl         (ctrl),
        .memory_word  (s1_item_reg.memory_word),
        .loaded_value (loaded_value)
    );

    // unmatched words leave every field zero (decode zeroes ctrl)
    always_comb
    begin
        s2_result_next                = '0;
        s2_result_next.matched        = ctrl.matched;
        s2_result_next.dest_index     = ctrl.dest_index;
        s2_result_next.source_index   = ctrl.source_index;
        s2_result_next.immediate      = ctrl.imm_out;
        s2_result_next.alu_result     = alu_result;
        s2_result_next.take_branch    = ctrl.take_branch;
        s2_result_next.write_register = ctrl.matched;
        s2_result_next.from_memory    = ctrl.from_memory;
        s2_result_next.access_size    = ctrl.access_size;
        s2_result_next.loaded_value   = loaded_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s1_ready)
            s1_item_reg <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
        if (s1_valid_reg && s2_ready)
            s2_result_reg <= s2_result_next;
    end

    assign m_axis_tvalid = s2_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-$bits(result_t)){1'b0}}, s2_result_reg};

    // A held input item must not change while the result stage is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_item_reg))
    else $error("input stage lost or changed a stalled item");

    // Unmatched results carry all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !s2_result_reg.matched |-> s2_result_reg == '0)
    else $error("unmatched result has nonzero fields");

    // Branch and load are exclusive, and both imply a register write
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (s2_result_reg.take_branch || s2_result_reg.from_memory)
        |-> s2_result_reg.write_register
            && !(s2_result_reg.take_branch && s2_result_reg.from_memory))
    else $error("inconsistent control flags");

    // Every valid input stage item reaches the result stage once it frees up
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_ready |=> s2_valid_reg)
    else $error("item dropped between stages");

endmodule

>>> design/rv64id_decode.sv
module rv64id_decode (
    input  logic [31:0]         instruction,
    output rv64id_pkg::ctrl_t   ctrl
);
    import rv64id_pkg::*;

    logic [6:0] opc;
    logic [2:0] f3;
    logic [5:0] top6;
    logic       is_shift;

    assign opc  = instruction[6:0];
    assign f3   = instruction[14:12];
    assign top6 = instruction[31:26];

    always_comb
    begin
        ctrl          = '0;
        ctrl.alu_op   = ALU_NONE;
        is_shift      = 1'b0;
        case (opc)
            OPC_JALR:
            begin
                if (f3 == F3_JALR)
                begin
                    ctrl.matched     = 1'b1;
                    ctrl.take_branch = 1'b1;
                    ctrl.alu_op      = ALU_LINK;
                end
            end
            OPC_LOAD:
            begin
                if (f3 != F3_LD_RSVD)
                begin
                    ctrl.matched       = 1'b1;
                    ctrl.from_memory   = 1'b1;
                    ctrl.alu_op        = ALU_ADD;
                    ctrl.access_size   = f3[1:0];
                    ctrl.load_unsigned = f3[2];
                end
            end
            OPC_OP_IMM:
            begin
                ctrl.matched = 1'b1;
                case (f3)
                    F3_ADD:  ctrl.alu_op = ALU_ADD;
                    F3_SLT:  ctrl.alu_op = ALU_SLT;
                    F3_SLTU: ctrl.alu_op = ALU_SLTU;
                    F3_XOR:  ctrl.alu_op = ALU_XOR;
                    F3_OR:   ctrl.alu_op = ALU_OR;
                    F3_AND:  ctrl.alu_op = ALU_AND;
                    F3_SLL:
                    begin
                        is_shift = 1'b1;
                        if (top6 == TOP6_LOGIC)
                            ctrl.alu_op = ALU_SLL;
                        else
                            ctrl.matched = 1'b0;
                    end
                    F3_SR:
                    begin
                        is_shift = 1'b1;
                        if (top6 == TOP6_LOGIC)
                            ctrl.alu_op = ALU_SRL;
                        else if (top6 == TOP6_ARITH)
                            ctrl.alu_op = ALU_SRA;
                        else
                            ctrl.matched = 1'b0;
                    end
                    default: ctrl.matched = 1'b0;
                endcase
                if (!ctrl.matched)
                    ctrl.alu_op = ALU_NONE;
            end
            default: ctrl.matched = 1'b0;
        endcase

        if (ctrl.matched)
        begin
            ctrl.dest_index   = instruction[11:7];
            ctrl.source_index = instruction[19:15];
            ctrl.imm_raw      = instruction[31:20];
            // shifts report only the shift amount
            ctrl.imm_out      = is_shift
                              ? {{(12-SHAMT_W){1'b0}}, instruction[20 +: SHAMT_W]}
                              : instruction[31:20];
        end
    end

endmodule

>>> design/rv64id_alu.sv
module rv64id_alu (
    input  rv64id_pkg::ctrl_t             ctrl,
    input  logic [rv64id_pkg::XLEN-1:0]   source_value,
    input  logic [rv64id_pkg::XLEN-1:0]   program_counter,
    output logic [rv64id_pkg::XLEN-1:0]   alu_result
);
    import rv64id_pkg::*;

    logic [XLEN-1:0]    imm64;
    logic [SHAMT_W-1:0] shamt;
    logic               lt_signed;
    logic               lt_unsigned;

    assign imm64       = {{(XLEN-12){ctrl.imm_raw[11]}}, ctrl.imm_raw};
    assign shamt       = ctrl.imm_raw[SHAMT_W-1:0];
    assign lt_signed   = $signed(source_value) < $signed(imm64);
    assign lt_unsigned = source_value < imm64;

    always_comb
    begin
        case (ctrl.alu_op)
            ALU_ADD:  alu_result = source_value + imm64;
            ALU_SLT:  alu_result = {{(XLEN-1){1'b0}}, lt_signed};
            ALU_SLTU: alu_result = {{(XLEN-1){1'b0}}, lt_unsigned};
            ALU_XOR:  alu_result = source_value ^ imm64;
            ALU_OR:   alu_result = source_value | imm64;
            ALU_AND:  alu_result = source_value & imm64;
            ALU_SLL:  alu_result = source_value << shamt;
            ALU_SRL:  alu_result = source_value >> shamt;
            ALU_SRA:  alu_result = XLEN'($signed(source_value) >>> shamt);
            ALU_LINK: alu_result = program_counter + XLEN'(4);
            default:  alu_result = '0;
        endcase
    end

endmodule

>>> design/rv64id_load_ext.sv
module rv64id_load_ext (
    input  rv64id_pkg::ctrl_t             ctrl,
    input  logic [rv64id_pkg::XLEN-1:0]   memory_word,
    output logic [rv64id_pkg::XLEN-1:0]   loaded_value
);
    import rv64id_pkg::*;

    logic fill_b;
    logic fill_h;
    logic fill_w;

    // sign fill per width, forced low for unsigned loads
    assign fill_b = memory_word[7]  & ~ctrl.load_unsigned;
    assign fill_h = memory_word[15] & ~ctrl.load_unsigned;
    assign fill_w = memory_word[31] & ~ctrl.load_unsigned;

    always_comb
    begin
        if (!ctrl.from_memory)
            loaded_value = '0;
        else
        begin
            case (ctrl.access_size)
                SIZE_BYTE:   loaded_value = {{(XLEN-8){fill_b}},  memory_word[7:0]};
                SIZE_HALF:   loaded_value = {{(XLEN-16){fill_h}}, memory_word[15:0]};
                SIZE_WORD:   loaded_value = {{(XLEN-32){fill_w}}, memory_word[31:0]};
                SIZE_DOUBLE: loaded_value = memory_word;
                default:     loaded_value = '0;
            endcase
        end
    end

endmodule

>>> dv/rv64i_itype_decode_execute_unit_test.sv
module rv64i_itype_decode_execute_unit_test;

    import rv64id_pkg::*;

    // Long receiver hold-off: at least this many cycles with m_axis_tready low.
    localparam int HOLD_CYCLES   = 300;
    // Watchdog: cycles without any transfer on either side before giving up.
    localparam int STALL_LIMIT   = 5000;
    // Extra cycles after the last expected result, to catch spurious outputs.
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 1500;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_NEG  = 64'h8000_0000_0000_0000;

    // Load funct3 codes
    localparam logic [2:0] F3_LB  = 3'b000;
    localparam logic [2:0] F3_LH  = 3'b001;
    localparam logic [2:0] F3_LW  = 3'b010;
    localparam logic [2:0] F3_LD  = 3'b011;
    localparam logic [2:0] F3_LBU = 3'b100;
    localparam logic [2:0] F3_LHU = 3'b101;
    localparam logic [2:0] F3_LWU = 3'b110;

    // One directed stimulus row. Rows with a hand-written answer carry it in
    // want; the rest are checked against decode_execute().
    typedef struct {
        item_t   stim;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [31:0] instruction, [95:32] source_value, [159:96] program_counter,
    // [223:160] memory_word
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [0] matched, [5:1] dest_index, [10:6] source_index, [22:11] immediate,
    // [86:23] alu_result, [87] take_branch, [88] write_register,
    // [89] from_memory, [91:90] access_size, [155:92] loaded_value
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    result_t   pending_results[$];   // decoded results still owed by the DUT
    stim_row_t directed[$];
    int        mismatches   = 0;
    int        results_seen = 0;
    int        quiet_cycles = 0;
    bit        steady       = 1'b0;  // both sides run without idling
    bit        hold_done    = 1'b0;
    result_t   want;
    result_t   got;

    rv64i_itype_decode_execute_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: decode one I-type word and execute it.
    // ------------------------------------------------------------------
    function automatic result_t decode_execute(item_t it);
        result_t            r;
        logic [6:0]         opc;
        logic [2:0]         f3;
        logic [11:0]        imm12;
        logic [5:0]         top6;
        logic [5:0]         shamt;
        logic [63:0]        imm;
        logic [63:0]        rs1_val;
        logic signed [63:0] rs1_s;
        logic signed [63:0] imm_s;
        logic [63:0]        mem;
        logic [63:0]        res;
        logic [63:0]        lv;
        logic [1:0]         size;
        logic               ok;
        logic               br;
        logic               ld;
        logic               is_shift;

        r        = '0;
        opc      = it.instruction[6:0];
        f3       = it.instruction[14:12];
        imm12    = it.instruction[31:20];
        top6     = it.instruction[31:26];
        shamt    = imm12[5:0];
        imm      = {{52{imm12[11]}}, imm12};
        rs1_val  = it.source_value;
        rs1_s    = it.source_value;
        imm_s    = imm;
        mem      = it.memory_word;
        res      = '0;
        lv       = '0;
        size     = SIZE_BYTE;
        ok       = 1'b0;
        br       = 1'b0;
        ld       = 1'b0;
        is_shift = 1'b0;

        if (opc == OPC_JALR && f3 == F3_JALR) begin
            ok  = 1'b1;
            br  = 1'b1;
            res = it.program_counter + 64'd4;
        end else if (opc == OPC_LOAD && f3 != F3_LD_RSVD) begin
            ok   = 1'b1;
            ld   = 1'b1;
            size = f3[1:0];
            res  = rs1_val + imm;
            // f3[2] selects zero extension (LBU, LHU, LWU)
            case (size)
                SIZE_BYTE:   lv = f3[2] ? {56'b0, mem[7:0]}  : {{56{mem[7]}}, mem[7:0]};
                SIZE_HALF:   lv = f3[2] ? {48'b0, mem[15:0]} : {{48{mem[15]}}, mem[15:0]};
                SIZE_WORD:   lv = f3[2] ? {32'b0, mem[31:0]} : {{32{mem[31]}}, mem[31:0]};
                default:     lv = mem;
            endcase
        end else if (opc == OPC_OP_IMM) begin
            ok = 1'b1;
            case (f3)
                F3_ADD:  res = rs1_val + imm;
                F3_SLT:  res = (rs1_s < imm_s) ? 64'd1 : 64'd0;
                F3_SLTU: res = (rs1_val < imm) ? 64'd1 : 64'd0;
                F3_XOR:  res = rs1_val ^ imm;
                F3_OR:   res = rs1_val | imm;
                F3_AND:  res = rs1_val & imm;
                F3_SLL:
                begin
                    is_shift = 1'b1;
                    if (top6 == TOP6_LOGIC)
                        res = rs1_val << shamt;
                    else
                        ok = 1'b0;
                end
                default:
                begin
                    is_shift = 1'b1;
                    if (top6 == TOP6_LOGIC)
                        res = rs1_val >> shamt;
                    else if (top6 == TOP6_ARITH)
                        res = rs1_s >>> shamt;
                    else
                        ok = 1'b0;
                end
            endcase
        end

        if (ok) begin
            r.matched        = 1'b1;
            r.dest_index     = it.instruction[11:7];
            r.source_index   = it.instruction[19:15];
            r.immediate      = is_shift ? {6'b0, shamt} : imm12;
            r.alu_result     = res;
            r.take_branch    = br;
            r.write_register = 1'b1;
            r.from_memory    = ld;
            r.access_size    = size;
            r.loaded_value   = lv;
        end
        return r;
    endfunction

    function automatic logic [31:0] encode_itype(logic [11:0] imm, logic [4:0] rs1,
                                                 logic [2:0] f3, logic [4:0] rd,
                                                 logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic item_t item_of(logic [31:0] word, logic [63:0] src,
                                      logic [63:0] pc, logic [63:0] mem);
        item_t it;
        it.instruction     = word;
        it.source_value    = src;
        it.program_counter = pc;
        it.memory_word     = mem;
        return it;
    endfunction

    function automatic stim_row_t row(item_t it, bit typed = 1'b0, result_t ans = '0);
        stim_row_t r;
        r.stim  = it;
        r.typed = typed;
        r.want  = ans;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly well-formed I-type words with random fields; about one in
    // seven is an arbitrary word, and a few shift, load and JALR encodings
    // are left with illegal upper bits or funct3.
    function automatic item_t random_item();
        logic [31:0] word;
        logic [63:0] src;
        int          pick;

        word = $urandom;
        pick = $urandom_range(99);
        if (pick < 40) begin
            word[6:0] = OPC_OP_IMM;
            if ($urandom_range(9) != 0) begin
                if (word[14:12] == F3_SLL)
                    word[31:26] = TOP6_LOGIC;
                else if (word[14:12] == F3_SR)
                    word[31:26] = $urandom_range(1) ? TOP6_LOGIC : TOP6_ARITH;
            end
        end else if (pick < 70) begin
            word[6:0] = OPC_LOAD;
        end else if (pick < 85) begin
            word[6:0] = OPC_JALR;
            if ($urandom_range(9) != 0)
                word[14:12] = F3_JALR;
        end

        case ($urandom_range(19))
            0:       src = '0;
            1:       src = ALL_ONES;
            2:       src = MAX_POS;
            3:       src = MIN_NEG;
            default: src = rand64();
        endcase
        return item_of(word, src, rand64(), rand64());
    endfunction

    // Offer one instruction; record its expected result once it transfers.
    task automatic offer(input stim_row_t r, input bit calm);
        if (!calm) begin
            while ($urandom_range(99) < 23) begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r.stim;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(r.typed ? r.want : decode_execute(r.stim));
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: every result transfer is matched against the oldest
    // pending expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result transfer with none expected, got %h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                got  = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
                check_field("matched",        64'(want.matched),
                            64'(got.matched));
                check_field("dest_index",     64'(want.dest_index),
                            64'(got.dest_index));
                check_field("source_index",   64'(want.source_index),
                            64'(got.source_index));
                check_field("immediate",      64'(want.immediate),
                            64'(got.immediate));
                check_field("alu_result",     want.alu_result,     got.alu_result);
                check_field("take_branch",    64'(want.take_branch),
                            64'(got.take_branch));
                check_field("write_register", 64'(want.write_register),
                            64'(got.write_register));
                check_field("from_memory",    64'(want.from_memory),
                            64'(got.from_memory));
                check_field("access_size",    64'(want.access_size),
                            64'(got.access_size));
                check_field("loaded_value",   want.loaded_value,   got.loaded_value);
                // byte padding above the last field must stay zero
                check_field("tdata padding", '0,
                            64'(m_axis_tdata[OUT_TDATA_W-1:$bits(result_t)]));
            end
        end
    end

    // Watchdog: give up after a long stretch with no transfer on either side.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, pending_results.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, one long hold-off so the two
    // pipeline registers fill and s_axis_tready drops, and a stall-free
    // stretch while the sender runs flat out.
    // ------------------------------------------------------------------
    initial begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (!hold_done && results_seen >= 300) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= 23);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender and run control.
    // ------------------------------------------------------------------
    initial begin
        result_t link_want;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;

        // Hand-written answers: unmatched words decode to all zeros.
        directed.push_back(row(item_of(32'h0000_0000, ALL_ONES, ALL_ONES, ALL_ONES), 1'b1));
        directed.push_back(row(item_of(32'hFFFF_FFFF, ALL_ONES, ALL_ONES, ALL_ONES), 1'b1));
        // load with the reserved funct3
        directed.push_back(row(item_of(encode_itype(12'h123, 5'd2, F3_LD_RSVD, 5'd3,
                               OPC_LOAD), MAX_POS, ALL_ONES, ALL_ONES), 1'b1));
        // JALR with a nonzero funct3
        directed.push_back(row(item_of(encode_itype(12'h004, 5'd1, F3_AND, 5'd1,
                               OPC_JALR), MAX_POS, ALL_ONES, ALL_ONES), 1'b1));
        // SLLI carrying the arithmetic pattern, SLLI with bit 26 set,
        // and a right shift whose upper bits match neither pattern
        directed.push_back(row(item_of(encode_itype({TOP6_ARITH, 6'd5}, 5'd4, F3_SLL, 5'd4,
                               OPC_OP_IMM), ALL_ONES, '0, '0), 1'b1));
        directed.push_back(row(item_of(encode_itype({6'b000001, 6'd5}, 5'd4, F3_SLL, 5'd4,
                               OPC_OP_IMM), ALL_ONES, '0, '0), 1'b1));
        directed.push_back(row(item_of(encode_itype({6'b100000, 6'd1}, 5'd4, F3_SR, 5'd4,
                               OPC_OP_IMM), ALL_ONES, '0, '0), 1'b1));

        // JALR at the top of the address space: link address wraps to 3.
        link_want                = '0;
        link_want.matched        = 1'b1;
        link_want.dest_index     = 5'd1;
        link_want.source_index   = 5'd31;
        link_want.immediate      = 12'h800;
        link_want.alu_result     = 64'd3;
        link_want.take_branch    = 1'b1;
        link_want.write_register = 1'b1;
        directed.push_back(row(item_of(encode_itype(12'h800, 5'd31, F3_JALR, 5'd1,
                               OPC_JALR), MIN_NEG, ALL_ONES, ALL_ONES), 1'b1, link_want));

        // Loads: every width, sign bits set in the raw data.
        directed.push_back(row(item_of(encode_itype(12'h7FF, 5'd6, F3_LB, 5'd5, OPC_LOAD),
                               MAX_POS, '0, 64'h0123_4567_89AB_CD80)));
        directed.push_back(row(item_of(encode_itype(12'h800, 5'd0, F3_LH, 5'd31, OPC_LOAD),
                               '0, '0, 64'h0123_4567_89AB_8000)));
        directed.push_back(row(item_of(encode_itype(12'hFFF, 5'd31, F3_LW, 5'd0, OPC_LOAD),
                               '0, '0, 64'h0123_4567_8000_0000)));
        directed.push_back(row(item_of(encode_itype(12'h001, 5'd7, F3_LD, 5'd8, OPC_LOAD),
                               ALL_ONES, '0, ALL_ONES)));
        directed.push_back(row(item_of(encode_itype(12'h010, 5'd9, F3_LBU, 5'd10, OPC_LOAD),
                               MIN_NEG, '0, ALL_ONES)));
        directed.push_back(row(item_of(encode_itype(12'h020, 5'd11, F3_LHU, 5'd12, OPC_LOAD),
                               MIN_NEG, '0, ALL_ONES)));
        directed.push_back(row(item_of(encode_itype(12'h040, 5'd13, F3_LWU, 5'd14, OPC_LOAD),
                               MIN_NEG, '0, ALL_ONES)));

        // Immediate ALU operations at the edges of the immediate and rs1.
        directed.push_back(row(item_of(encode_itype(12'hFFF, 5'd1, F3_ADD, 5'd2, OPC_OP_IMM),
                               '0, '0, '0)));
        directed.push_back(row(item_of(encode_itype(12'h800, 5'd1, F3_ADD, 5'd2, OPC_OP_IMM),
                               MIN_NEG, '0, '0)));
        directed.push_back(row(item_of(encode_itype(12'h000, 5'd1, F3_SLT, 5'd2, OPC_OP_IMM),
                               ALL_ONES, '0, '0)));
        directed.push_back(row(item_of(encode_itype(12'hFFF, 5'd1, F3_SLT, 5'd2, OPC_OP_IMM),
                               '0, '0, '0)));
        // SLTIU compares against the sign-extended immediate as unsigned
        directed.push_back(row(item_of(encode_itype(12'hFFF, 5'd1, F3_SLTU, 5'd2, OPC_OP_IMM),
                               '0, '0, '0)));
        directed.push_back(row(item_of(encode_itype(12'hFFF, 5'd1, F3_SLTU, 5'd2, OPC_OP_IMM),
                               ALL_ONES, '0, '0)));
        directed.push_back(row(item_of(encode_itype(12'h800, 5'd3, F3_XOR, 5'd4, OPC_OP_IMM),
                               MAX_POS, '0, '0)));
        directed.push_back(row(item_of(encode_itype(12'h800, 5'd3, F3_OR, 5'd4, OPC_OP_IMM),
                               64'h1, '0, '0)));
        directed.push_back(row(item_of(encode_itype(12'h7FF, 5'd3, F3_AND, 5'd4, OPC_OP_IMM),
                               ALL_ONES, '0, '0)));

        // Shifts by 0 and 63, arithmetic right shift of a negative value.
        directed.push_back(row(item_of(encode_itype({TOP6_LOGIC, 6'd63}, 5'd5, F3_SLL, 5'd6,
                               OPC_OP_IMM), 64'h1, '0, '0)));
        directed.push_back(row(item_of(encode_itype({TOP6_LOGIC, 6'd63}, 5'd5, F3_SR, 5'd6,
                               OPC_OP_IMM), MIN_NEG, '0, '0)));
        directed.push_back(row(item_of(encode_itype({TOP6_ARITH, 6'd63}, 5'd5, F3_SR, 5'd6,
                               OPC_OP_IMM), MIN_NEG, '0, '0)));
        directed.push_back(row(item_of(encode_itype({TOP6_ARITH, 6'd0}, 5'd5, F3_SR, 5'd6,
                               OPC_OP_IMM), MIN_NEG, '0, '0)));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            offer(directed[i], 1'b0);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // stall-free stretch on both sides in the middle of the run
            steady = (k >= 700 && k < 1000);
            offer(row(random_item()), steady);
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
